@@ rtl/core/block_partition_range_splitter_macros.svh @@
// assertion macros shared by the range splitter rtl
`ifndef BLOCK_PARTITION_RANGE_SPLITTER_MACROS_SVH
`define BLOCK_PARTITION_RANGE_SPLITTER_MACROS_SVH

// same-cycle implication, sampled on clk and masked during reset
`define BRPS_CHECK(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRPS_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/brps_pkg.sv @@
// package: widths, register codes and shared types of the range splitter
`timescale 1ns / 1ps
package brps_pkg;

  localparam int INDEX_BITS = 48;
  localparam int PART_BITS  = 16;
  localparam int MAX_CHUNKS = 64;

  localparam int PW       = PART_BITS + 1;          // part count width
  localparam int OPW      = INDEX_BITS + 2;         // internal arithmetic width
  localparam int CNT_W    = $clog2(MAX_CHUNKS + 1);
  localparam int DM_CNT_W = $clog2(OPW + 1);
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 64;

  localparam logic [PW-1:0] PARTS_MAX = PW'(1) << PART_BITS;

  localparam logic [1:0] REG_FIRST_INDEX = 2'd0;
  localparam logic [1:0] REG_TOTAL_COUNT = 2'd1;
  localparam logic [1:0] REG_NUM_PARTS   = 2'd2;
  localparam logic [1:0] REG_MY_PART     = 2'd3;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } op_t;

  // effective configuration after clamping
  typedef struct packed {
    logic [INDEX_BITS-1:0] first;
    logic [INDEX_BITS-1:0] total;
    logic [PW-1:0]         parts;
    logic [PART_BITS-1:0]  my_part;
  } cfg_t;

  typedef struct packed {
    logic           start;
    op_t            op;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
  } dm_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [OPW-1:0] quo;
    logic [OPW-1:0] rem;
  } dm_rsp_t;

endpackage

@@ rtl/core/brps_if.sv @@
// channel interfaces: input range words and result chunk words
`timescale 1ns / 1ps
interface brps_in_if;
  logic                            valid;
  logic                            ready;
  logic [brps_pkg::INDEX_BITS-1:0] range_start;
  logic [brps_pkg::INDEX_BITS-1:0] range_end;

  modport source (output valid, range_start, range_end, input ready);
  modport sink (input valid, range_start, range_end, output ready);
endinterface

interface brps_out_if;
  logic                           valid;
  logic                           ready;
  logic [brps_pkg::PART_BITS-1:0] owner;
  logic [brps_pkg::INDEX_BITS-1:0] chunk_start;
  logic [brps_pkg::INDEX_BITS-1:0] chunk_end;
  logic                           last;
  logic                           overflow;

  modport source (output valid, owner, chunk_start, chunk_end, last, overflow, input ready);
  modport sink (input valid, owner, chunk_start, chunk_end, last, overflow, output ready);
endinterface

@@ rtl/core/brps_cfg.sv @@
// configuration registers with apb-style access and clamped effective values
`timescale 1ns / 1ps
module brps_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brps_pkg::ADDR_W-1:0] paddr,
  input  logic [brps_pkg::DATA_W-1:0] pwdata,
  output logic [brps_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output brps_pkg::cfg_t              cfg
);

  logic [brps_pkg::INDEX_BITS-1:0] first_r;
  logic [brps_pkg::INDEX_BITS-1:0] total_r;
  logic [brps_pkg::PW-1:0]         parts_r;
  logic [brps_pkg::PART_BITS-1:0]  my_part_r;
  logic [1:0]                      sel;
  logic                            wr;
  logic [brps_pkg::INDEX_BITS-1:0] t_eff;
  logic [brps_pkg::PW-1:0]         p_eff;

  assign sel    = paddr[4:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= '0;
      total_r   <= brps_pkg::INDEX_BITS'(1);
      parts_r   <= brps_pkg::PW'(1);
      my_part_r <= '0;
    end else if (wr) begin
      case (sel)
        brps_pkg::REG_FIRST_INDEX: first_r   <= pwdata[brps_pkg::INDEX_BITS-1:0];
        brps_pkg::REG_TOTAL_COUNT: total_r   <= pwdata[brps_pkg::INDEX_BITS-1:0];
        brps_pkg::REG_NUM_PARTS:   parts_r   <= pwdata[brps_pkg::PW-1:0];
        brps_pkg::REG_MY_PART:     my_part_r <= pwdata[brps_pkg::PART_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      brps_pkg::REG_FIRST_INDEX: prdata = brps_pkg::DATA_W'(first_r);
      brps_pkg::REG_TOTAL_COUNT: prdata = brps_pkg::DATA_W'(total_r);
      brps_pkg::REG_NUM_PARTS:   prdata = brps_pkg::DATA_W'(parts_r);
      brps_pkg::REG_MY_PART:     prdata = brps_pkg::DATA_W'(my_part_r);
      default:                   prdata = '0;
    endcase
  end

  // zero acts as one, parts clamp to the part space and to the index count
  always_comb begin
    t_eff = (total_r == '0) ? brps_pkg::INDEX_BITS'(1) : total_r;
    p_eff = (parts_r == '0) ? brps_pkg::PW'(1) : parts_r;
    if (p_eff > brps_pkg::PARTS_MAX) p_eff = brps_pkg::PARTS_MAX;
    if (brps_pkg::INDEX_BITS'(p_eff) > t_eff) p_eff = t_eff[brps_pkg::PW-1:0];
  end

  assign cfg.first   = first_r;
  assign cfg.total   = t_eff;
  assign cfg.parts   = p_eff;
  assign cfg.my_part = my_part_r;

endmodule

@@ rtl/core/brps_divmul.sv @@
// shared bit-serial unit: restoring divide or shift-add multiply over one adder
`timescale 1ns / 1ps
module brps_divmul (
  input  logic              clk,
  input  logic              rst_n,
  input  brps_pkg::dm_req_t req,
  output brps_pkg::dm_rsp_t rsp
);

  localparam int W = brps_pkg::OPW;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  brps_pkg::op_t                 op_r, op_nxt;
  logic [brps_pkg::DM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]                  rem_r, rem_nxt;
  logic [W-1:0]                  quo_r, quo_nxt;
  logic [W-1:0]                  dvs_r, dvs_nxt;
  logic [W:0]                    rem_sh;
  logic [W:0]                    add_x, add_y;
  logic                          add_sub;
  logic [W+1:0]                  sum;

  assign rem_sh = {rem_r, quo_r[W-1]};

  // the one adder: subtract for divide steps, add for multiply steps
  always_comb begin
    if (op_r == brps_pkg::OP_DIV) begin
      add_x   = rem_sh;
      add_y   = {1'b0, dvs_r};
      add_sub = 1'b1;
    end else begin
      add_x   = {1'b0, rem_r};
      add_y   = {1'b0, dvs_r};
      add_sub = 1'b0;
    end
    sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (W+2)'(add_sub);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      rem_nxt  = '0;
      if (req.op == brps_pkg::OP_DIV) begin
        quo_nxt = req.a;
        dvs_nxt = req.b;
        cnt_nxt = brps_pkg::DM_CNT_W'(W);
      end else begin
        quo_nxt = req.b;
        dvs_nxt = req.a;
        cnt_nxt = brps_pkg::DM_CNT_W'(brps_pkg::PW);
      end
    end else if (busy_r) begin
      if (op_r == brps_pkg::OP_DIV) begin
        rem_nxt = sum[W+1] ? sum[W-1:0] : rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], sum[W+1]};
      end else begin
        if (quo_r[0]) rem_nxt = sum[W-1:0];
        quo_nxt = {1'b0, quo_r[W-1:1]};
        dvs_nxt = {dvs_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - brps_pkg::DM_CNT_W'(1);
      if (cnt_r == brps_pkg::DM_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= brps_pkg::OP_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ rtl/core/block_partition_range_splitter.sv @@
// top level: sequencer that splits owned ranges into per-owner chunks
// Usage: write first_index, total_count, num_parts and my_part over the apb-style
// port (8-byte register spacing) while the block is idle. Each input word carries
// an owned range [range_start, range_end]. The block drops the overlap with this
// part's own block and emits one output word per owning part, low to high, with
// last set on the final word and overflow set there when words past 64 were lost.
// An empty range, or one inside the own block, gives no words.
// Work per item: one 50-step divide for the block size, a 17-step multiply for the
// short-block border and, if this part owns a block, one for that block's start,
// then two 50-step owner divides per remaining segment, all on one shared
// divide/multiply unit. Words then follow one per cycle while the receiver takes
// them; a second segment first needs its own owner divides. The input side is
// ready only between items, so no new item is taken until the last is walked.
// A stalled receiver holds the output register and freezes the chunk walk.
// Reset (synchronous, rst_n low) returns the registers to their defaults, drops
// any item in flight and clears the output valid.
`timescale 1ns / 1ps
`include "block_partition_range_splitter_macros.svh"
module block_partition_range_splitter (
  input  logic                        clk,
  input  logic                        rst_n,
  brps_in_if.sink                     in_if,
  brps_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brps_pkg::ADDR_W-1:0] paddr,
  input  logic [brps_pkg::DATA_W-1:0] pwdata,
  output logic [brps_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int W  = brps_pkg::OPW;
  localparam int IB = brps_pkg::INDEX_BITS;
  localparam int PB = brps_pkg::PART_BITS;
  localparam int PW = brps_pkg::PW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SIZE  = 8'b0000_0010,
    S_SW    = 8'b0000_0100,
    S_BLK   = 8'b0000_1000,
    S_SEG   = 8'b0001_0000,
    S_OWN_S = 8'b0010_0000,
    S_OWN_E = 8'b0100_0000,
    S_WALK  = 8'b1000_0000
  } state_t;

  brps_pkg::cfg_t    cfg;
  brps_pkg::dm_req_t dm_req;
  brps_pkg::dm_rsp_t dm_rsp;

  state_t state_r, state_nxt;
  logic   go_r, go_nxt;

  // item and derived block geometry
  logic [IB-1:0] rs_r, rs_nxt, re_r, re_nxt;
  logic [IB-1:0] size_r, size_nxt;
  logic [PW-1:0] extra_r, extra_nxt;
  logic [W-1:0]  sw_r, sw_nxt;          // offset where the short blocks begin
  logic [W-1:0]  bs_r, bs_nxt, be_r, be_nxt;

  // segment being split and the one waiting behind it
  logic [IB-1:0] seg_s_r, seg_s_nxt, seg_e_r, seg_e_nxt;
  logic [IB-1:0] seg2_s_r, seg2_s_nxt, seg2_e_r, seg2_e_nxt;
  logic          seg2_v_r, seg2_v_nxt;

  // chunk walk
  logic [PB-1:0]                o_r, o_nxt, oe_r, oe_nxt;
  logic [W-1:0]                 bst_r, bst_nxt;   // absolute start of block o
  logic [W-1:0]                 cs_r, cs_nxt;
  logic [brps_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  // output register
  logic          ov_r, ov_nxt;
  logic [PB-1:0] o_own_r, o_own_nxt;
  logic [IB-1:0] o_cs_r, o_cs_nxt, o_ce_r, o_ce_nxt;
  logic          o_last_r, o_last_nxt, o_ovf_r, o_ovf_nxt;

  logic [W-1:0] first_x, t_x, size_x, extra_x, mp_x, rs_x, re_x;
  logic [W-1:0] q_idx, q_off, q_own, q_bstart;
  logic         q_below, q_above, q_in_sw;
  logic [PB-1:0] q_owner;
  logic [W-1:0] len_x, ce_blk, ce_cur, blk_min, bs_new;
  logic         no_blk, slot_free, more, at_cap, last_c;

  brps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brps_divmul u_dm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dm_req),
    .rsp   (dm_rsp)
  );

  assign first_x = W'(cfg.first);
  assign t_x     = W'(cfg.total);
  assign size_x  = W'(size_r);
  assign extra_x = W'(extra_r);
  assign mp_x    = W'(cfg.my_part);
  assign rs_x    = W'(rs_r);
  assign re_x    = W'(re_r);
  assign no_blk  = PW'(cfg.my_part) >= cfg.parts;

  // owner lookup for the segment's start or end
  always_comb begin
    q_idx   = (state_r == S_OWN_S) ? W'(seg_s_r) : W'(seg_e_r);
    q_below = q_idx < first_x;
    q_off   = q_idx - first_x;
    q_above = q_off >= t_x;
    q_in_sw = q_off >= sw_r;
    q_own   = q_in_sw ? extra_x + dm_rsp.quo : dm_rsp.quo;
    if (q_below)      q_owner = '0;
    else if (q_above) q_owner = PB'(cfg.parts - PW'(1));
    else              q_owner = q_own[PB-1:0];
    q_bstart = q_below ? '0 : q_off - dm_rsp.rem;
  end

  // one request at a time to the shared unit
  always_comb begin
    dm_req.start = go_r;
    dm_req.op    = brps_pkg::OP_DIV;
    dm_req.a     = q_in_sw ? q_off - sw_r : q_off;
    dm_req.b     = q_in_sw ? size_x : size_x + W'(1);
    case (state_r)
      S_SIZE: begin
        dm_req.a = t_x;
        dm_req.b = W'(cfg.parts);
      end
      S_SW: begin
        dm_req.op = brps_pkg::OP_MUL;
        dm_req.a  = size_x + W'(1);
        dm_req.b  = extra_x;
      end
      S_BLK: begin
        dm_req.op = brps_pkg::OP_MUL;
        dm_req.a  = size_x;
        dm_req.b  = mp_x;
      end
      default: ;
    endcase
  end

  // chunk geometry for the walk
  always_comb begin
    len_x     = size_x + ((W'(o_r) < extra_x) ? W'(1) : W'(0));
    ce_blk    = bst_r + len_x - W'(1);
    ce_cur    = (o_r == oe_r) ? W'(seg_e_r) : ce_blk;
    more      = (o_r != oe_r) || seg2_v_r;
    at_cap    = cnt_r == brps_pkg::CNT_W'(brps_pkg::MAX_CHUNKS - 1);
    last_c    = !more || at_cap;
    slot_free = !ov_r || out_if.ready;
    blk_min   = (mp_x < extra_x) ? mp_x : extra_x;
    bs_new    = first_x + dm_rsp.rem + blk_min;
  end

  always_comb begin
    state_nxt  = state_r;
    go_nxt     = 1'b0;
    rs_nxt     = rs_r;
    re_nxt     = re_r;
    size_nxt   = size_r;
    extra_nxt  = extra_r;
    sw_nxt     = sw_r;
    bs_nxt     = bs_r;
    be_nxt     = be_r;
    seg_s_nxt  = seg_s_r;
    seg_e_nxt  = seg_e_r;
    seg2_s_nxt = seg2_s_r;
    seg2_e_nxt = seg2_e_r;
    seg2_v_nxt = seg2_v_r;
    o_nxt      = o_r;
    oe_nxt     = oe_r;
    bst_nxt    = bst_r;
    cs_nxt     = cs_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = ov_r && !out_if.ready;
    o_own_nxt  = o_own_r;
    o_cs_nxt   = o_cs_r;
    o_ce_nxt   = o_ce_r;
    o_last_nxt = o_last_r;
    o_ovf_nxt  = o_ovf_r;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          rs_nxt  = in_if.range_start;
          re_nxt  = in_if.range_end;
          cnt_nxt = '0;
          // empty range: nothing to do
          if (in_if.range_start <= in_if.range_end) begin
            state_nxt = S_SIZE;
            go_nxt    = 1'b1;
          end
        end
      end
      S_SIZE: begin
        if (dm_rsp.done) begin
          size_nxt  = dm_rsp.quo[IB-1:0];
          extra_nxt = dm_rsp.rem[PW-1:0];
          state_nxt = S_SW;
          go_nxt    = 1'b1;
        end
      end
      S_SW: begin
        if (dm_rsp.done) begin
          sw_nxt = dm_rsp.rem;
          go_nxt = 1'b1;
          if (no_blk) begin
            // no own block: split the whole range
            seg_s_nxt  = rs_r;
            seg_e_nxt  = re_r;
            seg2_v_nxt = 1'b0;
            state_nxt  = S_OWN_S;
          end else begin
            state_nxt = S_BLK;
          end
        end
      end
      S_BLK: begin
        if (dm_rsp.done) begin
          bs_nxt    = bs_new;
          be_nxt    = bs_new + size_x + ((mp_x < extra_x) ? W'(1) : W'(0)) - W'(1);
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        seg2_v_nxt = 1'b0;
        go_nxt     = 1'b1;
        state_nxt  = S_OWN_S;
        if (be_r < rs_x || re_x < bs_r) begin
          seg_s_nxt = rs_r;
          seg_e_nxt = re_r;
        end else if (rs_x < bs_r) begin
          // part below the own block, maybe one above it too
          seg_s_nxt  = rs_r;
          seg_e_nxt  = IB'(bs_r - W'(1));
          seg2_s_nxt = IB'(be_r + W'(1));
          seg2_e_nxt = re_r;
          seg2_v_nxt = be_r < re_x;
        end else if (be_r < re_x) begin
          seg_s_nxt = IB'(be_r + W'(1));
          seg_e_nxt = re_r;
        end else begin
          // range lies inside the own block
          go_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_OWN_S: begin
        if (dm_rsp.done) begin
          o_nxt     = q_owner;
          bst_nxt   = first_x + q_bstart;
          cs_nxt    = W'(seg_s_r);
          go_nxt    = 1'b1;
          state_nxt = S_OWN_E;
        end
      end
      S_OWN_E: begin
        if (dm_rsp.done) begin
          oe_nxt    = q_owner;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          o_own_nxt  = o_r;
          o_cs_nxt   = cs_r[IB-1:0];
          o_ce_nxt   = ce_cur[IB-1:0];
          o_last_nxt = last_c;
          o_ovf_nxt  = more && at_cap;
          cnt_nxt    = cnt_r + brps_pkg::CNT_W'(1);
          if (last_c) begin
            state_nxt = S_IDLE;
          end else if (o_r == oe_r) begin
            // move on to the segment above the own block
            seg_s_nxt  = seg2_s_r;
            seg_e_nxt  = seg2_e_r;
            seg2_v_nxt = 1'b0;
            go_nxt     = 1'b1;
            state_nxt  = S_OWN_S;
          end else begin
            o_nxt   = o_r + PB'(1);
            bst_nxt = ce_blk + W'(1);
            cs_nxt  = ce_blk + W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      go_r     <= 1'b0;
      ov_r     <= 1'b0;
      cnt_r    <= '0;
      seg2_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      go_r     <= go_nxt;
      ov_r     <= ov_nxt;
      cnt_r    <= cnt_nxt;
      seg2_v_r <= seg2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r     <= rs_nxt;
    re_r     <= re_nxt;
    size_r   <= size_nxt;
    extra_r  <= extra_nxt;
    sw_r     <= sw_nxt;
    bs_r     <= bs_nxt;
    be_r     <= be_nxt;
    seg_s_r  <= seg_s_nxt;
    seg_e_r  <= seg_e_nxt;
    seg2_s_r <= seg2_s_nxt;
    seg2_e_r <= seg2_e_nxt;
    o_r      <= o_nxt;
    oe_r     <= oe_nxt;
    bst_r    <= bst_nxt;
    cs_r     <= cs_nxt;
    o_own_r  <= o_own_nxt;
    o_cs_r   <= o_cs_nxt;
    o_ce_r   <= o_ce_nxt;
    o_last_r <= o_last_nxt;
    o_ovf_r  <= o_ovf_nxt;
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = ov_r;
  assign out_if.owner       = o_own_r;
  assign out_if.chunk_start = o_cs_r;
  assign out_if.chunk_end   = o_ce_r;
  assign out_if.last        = o_last_r;
  assign out_if.overflow    = o_ovf_r;

  `BRPS_CHECK(a_ovf_on_last, out_if.valid && out_if.overflow, out_if.last, "overflow without last")
  `BRPS_CHECK(a_walk_cap, state_r == S_WALK, cnt_r < brps_pkg::CNT_W'(brps_pkg::MAX_CHUNKS), "over limit")
  `BRPS_CHECK(a_walk_owner, state_r == S_WALK, o_r <= oe_r, "walk owner past end owner")
  `BRPS_CHECK_NEXT(a_dm_start, dm_req.start, dm_rsp.busy, "shared unit did not start")

endmodule

@@ tb/block_partition_range_splitter_test.sv @@
// testbench for the block partition range splitter: directed and random ranges
`timescale 1ns / 1ps
module block_partition_range_splitter_test;

  typedef longint unsigned u64_t;

  // one chunk word as the block should send it
  typedef struct {
    logic [brps_pkg::PART_BITS-1:0]  owner;
    logic [brps_pkg::INDEX_BITS-1:0] chunk_start;
    logic [brps_pkg::INDEX_BITS-1:0] chunk_end;
    logic                            last;
    logic                            overflow;
  } chunk_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [brps_pkg::ADDR_W-1:0] paddr = '0;
  logic [brps_pkg::DATA_W-1:0] pwdata = '0;
  logic [brps_pkg::DATA_W-1:0] prdata;
  logic pready;

  brps_in_if in_if ();
  brps_out_if out_if ();

  block_partition_range_splitter uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam u64_t IDX_TOP = (u64_t'(1) << brps_pkg::INDEX_BITS) - 1;

  // shadow copy of the register file
  u64_t sh_first = 0;
  u64_t sh_total = 1;
  u64_t sh_parts = 1;
  u64_t sh_mine = 0;

  chunk_t chunks_due[$];   // words still owed by the block, oldest first
  chunk_t chunk_plan[$];   // words worked out for the current item
  bit chunks_lost;

  int mismatches = 0;
  int ranges_sent = 0;
  int words_seen = 0;
  int overflow_words = 0;
  int settings_used = 0;
  bit steady = 1'b0;        // when set neither side idles

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  // zero total acts as one index
  function automatic u64_t space_size();
    return (sh_total != 0) ? sh_total : 1;
  endfunction

  // part count after the zero, width and index-count clamps
  function automatic u64_t part_count();
    u64_t p;
    p = (sh_parts != 0) ? sh_parts : 1;
    if (p > (u64_t'(1) << brps_pkg::PART_BITS)) p = u64_t'(1) << brps_pkg::PART_BITS;
    if (p > space_size()) p = space_size();
    return p;
  endfunction

  // offset of the first index of block k
  function automatic u64_t block_lo(u64_t k);
    u64_t sz, extra;
    sz = space_size() / part_count();
    extra = space_size() - sz * part_count();
    return sz * k + ((k < extra) ? k : extra);
  endfunction

  // offset of the last index of block k
  function automatic u64_t block_hi(u64_t k);
    u64_t sz, extra, k1;
    sz = space_size() / part_count();
    extra = space_size() - sz * part_count();
    k1 = k + 1;
    return sz * k1 + ((k1 < extra) ? k1 : extra) - 1;
  endfunction

  // owning part of a global index; indices outside the space clamp to the ends
  function automatic u64_t owner_at(u64_t idx);
    u64_t p, t, sz, extra, border, off;
    p = part_count();
    t = space_size();
    sz = t / p;
    extra = t - sz * p;
    border = (sz + 1) * extra;
    if (idx < sh_first) return 0;
    off = idx - sh_first;
    if (off >= t) return p - 1;
    if (off >= border) return extra + (off - border) / sz;
    return off / (sz + 1);
  endfunction

  function automatic void add_chunk(u64_t own, u64_t s, u64_t e);
    chunk_t c;
    if (chunk_plan.size() >= brps_pkg::MAX_CHUNKS) begin
      chunks_lost = 1'b1;
      return;
    end
    c.owner = own[brps_pkg::PART_BITS-1:0];
    c.chunk_start = s[brps_pkg::INDEX_BITS-1:0];
    c.chunk_end = e[brps_pkg::INDEX_BITS-1:0];
    c.last = 1'b0;
    c.overflow = 1'b0;
    chunk_plan.push_back(c);
  endfunction

  // cut one segment at block borders, one chunk per owner
  function automatic void cut_segment(u64_t s, u64_t e);
    u64_t o_lo, o_hi, o, cs, ce;
    o_lo = owner_at(s);
    o_hi = owner_at(e);
    o = o_lo;
    while (1) begin
      cs = (o == o_lo) ? s : sh_first + block_lo(o);
      ce = (o == o_hi) ? e : sh_first + block_hi(o);
      add_chunk(o, cs, ce);
      if (o >= o_hi) break;
      if (chunk_plan.size() >= brps_pkg::MAX_CHUNKS) begin
        chunks_lost = 1'b1;
        break;
      end
      o++;
    end
  endfunction

  // queue the words that one accepted range should produce
  function automatic void forecast_chunks(u64_t rs, u64_t re);
    u64_t bs, be;
    chunk_plan.delete();
    chunks_lost = 1'b0;
    if (rs > re) return;
    if (sh_mine >= part_count()) begin
      cut_segment(rs, re);
    end else begin
      bs = sh_first + block_lo(sh_mine);
      be = sh_first + block_hi(sh_mine);
      if (be < rs || re < bs) begin
        cut_segment(rs, re);
      end else begin
        // own block is carved out, leaving up to two pieces
        if (rs < bs) cut_segment(rs, bs - 1);
        if (be < re) cut_segment(be + 1, re);
      end
    end
    if (chunk_plan.size() > 0) begin
      chunk_plan[chunk_plan.size()-1].last = 1'b1;
      chunk_plan[chunk_plan.size()-1].overflow = chunks_lost;
    end
    foreach (chunk_plan[i]) chunks_due.push_back(chunk_plan[i]);
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic u64_t rand48();
    return {$urandom, $urandom} & IDX_TOP;
  endfunction

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 9);
  endfunction

  // result side stalls at random
  always @(negedge clk) out_if.ready <= !take_gap();

  // send one range word and record what it should yield
  task automatic send_range(u64_t rs, u64_t re);
    while (take_gap()) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.range_start = rs[brps_pkg::INDEX_BITS-1:0];
    in_if.range_end = re[brps_pkg::INDEX_BITS-1:0];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    forecast_chunks(rs & IDX_TOP, re & IDX_TOP);
    ranges_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // two-phase register write, setup then access
  task automatic reg_write(logic [1:0] code, u64_t value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {code, 3'b000};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // let the block run dry: an item with no words may still be busy, so wait
  // out roughly its worst latency too
  task automatic wait_idle();
    while (chunks_due.size() != 0) @(posedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic apply_setting(u64_t first, u64_t total, u64_t parts, u64_t mine);
    wait_idle();
    reg_write(brps_pkg::REG_FIRST_INDEX, first);
    reg_write(brps_pkg::REG_TOTAL_COUNT, total);
    reg_write(brps_pkg::REG_NUM_PARTS, parts);
    reg_write(brps_pkg::REG_MY_PART, mine);
    sh_first = first & IDX_TOP;
    sh_total = total & IDX_TOP;
    sh_parts = parts & ((u64_t'(1) << brps_pkg::PW) - 1);
    sh_mine = mine & ((u64_t'(1) << brps_pkg::PART_BITS) - 1);
    settings_used++;
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    chunk_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      words_seen++;
      if (out_if.overflow) overflow_words++;
      if (chunks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: owner %0d [%0h..%0h]", out_if.owner,
                   out_if.chunk_start, out_if.chunk_end);
      end else begin
        want = chunks_due.pop_front();
        if (out_if.owner !== want.owner || out_if.chunk_start !== want.chunk_start ||
            out_if.chunk_end !== want.chunk_end || out_if.last !== want.last ||
            out_if.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %0d [%0h..%0h] l%0b o%0b, got %0d [%0h..%0h] l%0b o%0b",
                     want.owner, want.chunk_start, want.chunk_end, want.last,
                     want.overflow, out_if.owner, out_if.chunk_start,
                     out_if.chunk_end, out_if.last, out_if.overflow);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // registers at reset: a one-index space fully owned by this part
  task automatic test_reset_defaults();
    send_range(0, 0);
    send_range(0, 5);
    send_range(3, 9);
    send_range(9, 3);
  endtask

  // edge cases of the range and of the register clamps
  task automatic test_directed_cases();
    apply_setting(1000, 1000, 10, 3);
    send_range(1300, 1399);          // exactly the own block
    send_range(1250, 1450);          // own block in the middle, two pieces
    send_range(0, 999);              // wholly below the space
    send_range(1999, IDX_TOP);       // tail and beyond the space
    send_range(0, IDX_TOP);          // whole width
    send_range(1500, 1400);          // empty
    apply_setting(0, 100, 7, 6);     // uneven blocks, own block is the last
    send_range(0, 99);
    send_range(14, 15);              // across the border of blocks 0 and 1
    apply_setting(5, 3, 0, 0);       // zero parts acts as one
    send_range(0, 20);
    apply_setting(0, 5, 131071, 9);  // saturated parts, more parts than indices
    send_range(0, 10);
    apply_setting(0, 0, 4, 0);       // zero total acts as one
    send_range(0, 3);
    apply_setting(0, IDX_TOP, 65536, 65535);
    send_range(0, IDX_TOP);          // far too many chunks, overflow
    send_range(IDX_TOP, IDX_TOP);
    apply_setting(IDX_TOP, IDX_TOP, 3, 1);  // space wraps past the index width
    send_range(0, IDX_TOP);
    send_range(IDX_TOP, IDX_TOP);
  endtask

  // random settings, mostly ranges placed around the space
  task automatic test_random_ranges();
    u64_t parts, total, first, span, rs, re;
    for (int blk = 0; blk < 35; blk++) begin
      steady = (blk >= 12 && blk < 18);
      parts = ($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(1, 20);
      case ($urandom_range(3))
        0: total = $urandom_range(0, 40);
        1: total = rand48();
        default: total = $urandom_range(1, 5000);
      endcase
      first = ($urandom_range(3) == 0) ? rand48() : $urandom_range(5000);
      apply_setting(first, total, parts,
                    ($urandom_range(3) == 0) ? $urandom_range(65535)
                                             : $urandom_range(parts + 2));
      span = (sh_total != 0) ? sh_total : 1;
      for (int i = 0; i < 10; i++) begin
        case ($urandom_range(9))
          0: begin
            rs = rand48();
            re = rand48();
          end
          1: begin
            rs = sh_first + rand48() % (span + 20) - 10;
            re = rs - $urandom_range(1, 50);
          end
          default: begin
            // near the space, a handful of blocks long
            rs = sh_first + rand48() % (span + 20) - 10;
            re = rs + rand48() % ((span / part_count()) * $urandom_range(1, 6) + 3);
          end
        endcase
        send_range(rs, re);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.range_start = '0;
    in_if.range_end = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_random_ranges();
    wait_idle();
    $display("sent %0d ranges over %0d register settings", ranges_sent, settings_used);
    $display("checked %0d chunk words, %0d of them with overflow", words_seen,
             overflow_words);
    if (mismatches == 0 && chunks_due.size() == 0) begin
      $display("block_partition_range_splitter test passed");
    end else begin
      $display("block_partition_range_splitter test failed");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #40ms;
    $display("block_partition_range_splitter test failed");
    $finish;
  end

endmodule
